FILE: rtl/core/gcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gap cluster mean filter package
// Shared constants, register indexes and the divider status type.
// ----------------------------------------------------------------------------
package gcm_pkg;

  // Parameter defaults.
  localparam int MaxSetItemsDefault = 1024;
  localparam int CoordBitsDefault   = 12;

  // Configuration register widths and reset values.
  localparam int ImageSizeBits  = 12;
  localparam int MinMembersBits = 11;
  localparam int CfgDataBits    = 12;
  localparam int CfgIndexBits   = 1;

  localparam logic [ImageSizeBits-1:0]  ImageSizeReset  = 12'd512;
  localparam logic [MinMembersBits-1:0] MinMembersReset = 11'd6;

  // Register indexes on the configuration port.
  localparam logic [CfgIndexBits-1:0] REG_IMAGE_SIZE  = 1'd0;
  localparam logic [CfgIndexBits-1:0] REG_MIN_MEMBERS = 1'd1;

  // A neighbor joins the cluster while GapFactor * gap < image_size.
  localparam int GapFactor     = 54;
  localparam int GapFactorBits = 6;

  // Handshake status of the shared divider.
  typedef struct packed {
    logic busy;
    logic done;
  } gcm_div_status_t;

endpackage

FILE: rtl/core/gcm_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gap cluster mean divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gcm_divider #(
  parameter int DIVIDEND_W = 22,
  parameter int DIVISOR_W  = 11
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [DIVIDEND_W-1:0]    dividend,
  input  logic [DIVISOR_W-1:0]     divisor,
  output logic [DIVIDEND_W-1:0]    quotient,
  output gcm_pkg::gcm_div_status_t status
);
  import gcm_pkg::*;

  localparam int StepBits = $clog2(DIVIDEND_W + 1);

  logic [DIVISOR_W-1:0]  rem;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W-1:0]  divisor_hold;
  logic [StepBits-1:0]   steps;
  logic                  busy;
  logic                  done;

  logic [DIVISOR_W:0]   shifted;
  logic [DIVISOR_W+1:0] trial;
  logic                 fits;

  // Bring down the next dividend bit and try one subtraction.
  always_comb begin
    shifted = {rem, quo[DIVIDEND_W-1]};
    trial   = {1'b0, shifted} - {2'b00, divisor_hold};
    fits    = ~trial[DIVISOR_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= StepBits'(DIVIDEND_W);
      end else if (busy) begin
        steps <= steps - StepBits'(1);
        if (steps == StepBits'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem          <= '0;
      quo          <= dividend;
      divisor_hold <= divisor;
    end else if (busy) begin
      rem <= fits ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      quo <= {quo[DIVIDEND_W-2:0], fits};
    end
  end

  assign quotient    = quo;
  assign status.busy = busy;
  assign status.done = done;

endmodule

FILE: rtl/core/gap_cluster_mean_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gap cluster mean filter
// Groups ascending coordinates into clusters and reports each cluster's mean.
// ----------------------------------------------------------------------------
// The block takes one coordinate per beat, in ascending order, with
// last_of_set on the final beat of a set. A coordinate joins the open cluster
// while 54 times its distance to the previous coordinate is below image_size;
// otherwise the open cluster closes and a new one starts. A closing cluster
// whose member count exceeds min_members_exclusive produces a result beat with
// has_line set and line_position equal to the truncated mean of its members.
// The last coordinate of a set always produces one extra result beat with
// end_of_set set, carrying the final cluster's mean when it qualifies and
// has_line low otherwise. count_overflow reports that a cluster saturated at
// MAX_SET_ITEMS members during the set; further members are then dropped.
// The block works on one input beat at a time and holds in_ready low while it
// is busy. Each reported mean comes from a single shared restoring divider
// that works through the cluster sum one bit at a time (COORD_BITS plus log2
// of MAX_SET_ITEMS bits, 22 at the defaults); the sequencer then sees the
// divider finish and loads the output register. A beat that closes one
// reported cluster and ends its set with another runs the divider twice. A
// result beat waits in an output register until it is taken; a second result
// waits in the sequencer meanwhile, which keeps the block busy for as long as
// the output is held off. Configuration writes are accepted only while the
// block is idle between input beats, and never during reset.
// ----------------------------------------------------------------------------
module gap_cluster_mean_filter #(
  parameter int MAX_SET_ITEMS = gcm_pkg::MaxSetItemsDefault,
  parameter int COORD_BITS    = gcm_pkg::CoordBitsDefault
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write channel.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gcm_pkg::CfgIndexBits-1:0] cfg_index,
  input  logic [gcm_pkg::CfgDataBits-1:0]  cfg_data,
  // Input channel.
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [COORD_BITS-1:0]           coordinate,
  input  logic                            last_of_set,
  // Output channel.
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [COORD_BITS-1:0]           line_position,
  output logic                            has_line,
  output logic                            end_of_set,
  output logic                            count_overflow
);
  import gcm_pkg::*;

  // Widths that follow from the parameters.
  localparam int CountBits = $clog2(MAX_SET_ITEMS + 1);
  localparam int SumBits   = COORD_BITS + $clog2(MAX_SET_ITEMS);
  localparam int ProdBits  = COORD_BITS + GapFactorBits;
  localparam int CmpBits   = (CountBits > MinMembersBits) ? CountBits : MinMembersBits;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GAP  = 3'd1;
  localparam logic [2:0] S_TEST = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;
  localparam logic [2:0] S_LAST = 3'd5;

  logic [2:0] state;

  // Configuration registers.
  logic [ImageSizeBits-1:0]  image_size;
  logic [MinMembersBits-1:0] min_members_exclusive;

  // Set state.
  logic [COORD_BITS-1:0] previous_value;
  logic [SumBits-1:0]    cluster_sum;
  logic [CountBits-1:0]  cluster_count;
  logic                  cluster_open;
  logic                  overflow_seen;

  // Current beat and working registers.
  logic [COORD_BITS-1:0] coord_hold;
  logic                  last_hold;
  logic [COORD_BITS-1:0] gap;
  logic                  final_phase;
  logic                  line_flag;

  // Divider connection.
  logic                  div_start;
  logic [SumBits-1:0]    div_quotient;
  gcm_div_status_t       div_status;

  logic [ProdBits-1:0] gap_scaled;
  logic                joins;
  logic                reported;
  logic                break_report;
  logic                out_load;

  assign cfg_ready = !rst && (state == S_IDLE);
  assign in_ready  = !rst && (state == S_IDLE);

  // The gap test is an exact integer compare against the scaled gap.
  assign gap_scaled = ProdBits'(gap) * ProdBits'(GapFactor);
  assign joins      = gap_scaled < ProdBits'(image_size);

  // A cluster is reported when it is open and has enough members.
  assign reported = cluster_open &&
                    (CmpBits'(cluster_count) > CmpBits'(min_members_exclusive));

  // A break in the chain closes a cluster that may need its mean reported.
  assign break_report = cluster_open && !joins && reported;

  assign div_start = ((state == S_TEST) && break_report) ||
                     ((state == S_LAST) && last_hold && reported);

  // The output register is free when empty or when its beat leaves now.
  assign out_load = (state == S_EMIT) && (!out_valid || out_ready);

  gcm_divider #(
    .DIVIDEND_W(SumBits),
    .DIVISOR_W (CountBits)
  ) u_divider (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(cluster_sum),
    .divisor (cluster_count),
    .quotient(div_quotient),
    .status  (div_status)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_size            <= ImageSizeReset;
      min_members_exclusive <= MinMembersReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IMAGE_SIZE:  image_size            <= cfg_data[ImageSizeBits-1:0];
        REG_MIN_MEMBERS: min_members_exclusive <= cfg_data[MinMembersBits-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and set state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      previous_value <= '0;
      cluster_sum    <= '0;
      cluster_count  <= '0;
      cluster_open   <= 1'b0;
      overflow_seen  <= 1'b0;
      final_phase    <= 1'b0;
      line_flag      <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_GAP;
          end
        end
        S_GAP: begin
          state <= S_TEST;
        end
        S_TEST: begin
          previous_value <= coord_hold;
          if (break_report) begin
            // Report the old cluster first; the new one starts after the beat.
            final_phase <= 1'b0;
            line_flag   <= 1'b1;
            state       <= S_DIV;
          end else begin
            if (cluster_open && joins) begin
              if (cluster_count < CountBits'(MAX_SET_ITEMS)) begin
                cluster_count <= cluster_count + CountBits'(1);
                cluster_sum   <= cluster_sum + SumBits'(coord_hold);
              end else begin
                overflow_seen <= 1'b1;
              end
            end else begin
              cluster_open  <= 1'b1;
              cluster_count <= CountBits'(1);
              cluster_sum   <= SumBits'(coord_hold);
            end
            state <= S_LAST;
          end
        end
        S_LAST: begin
          if (!last_hold) begin
            state <= S_IDLE;
          end else if (reported) begin
            final_phase <= 1'b1;
            line_flag   <= 1'b1;
            state       <= S_DIV;
          end else begin
            final_phase <= 1'b1;
            line_flag   <= 1'b0;
            state       <= S_EMIT;
          end
        end
        S_DIV: begin
          if (div_status.done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_load) begin
            if (final_phase) begin
              previous_value <= '0;
              cluster_sum    <= '0;
              cluster_count  <= '0;
              cluster_open   <= 1'b0;
              overflow_seen  <= 1'b0;
              state          <= S_IDLE;
            end else begin
              cluster_open  <= 1'b1;
              cluster_count <= CountBits'(1);
              cluster_sum   <= SumBits'(coord_hold);
              state         <= S_LAST;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Beat capture and the gap, kept as an absolute difference.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      coord_hold <= coordinate;
      last_hold  <= last_of_set;
    end
    if (state == S_GAP) begin
      gap <= (coord_hold >= previous_value) ? coord_hold - previous_value
                                            : previous_value - coord_hold;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      line_position  <= line_flag ? div_quotient[COORD_BITS-1:0] : '0;
      has_line       <= line_flag;
      end_of_set     <= final_phase;
      count_overflow <= overflow_seen;
    end
  end

  // The divider is never restarted while it is still working.
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_status.busy)
    else $error("divider started while busy");

  // The member count never passes the saturation limit.
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    cluster_count <= CountBits'(MAX_SET_ITEMS))
    else $error("cluster count above limit");

  // A closed cluster holds no members and no sum.
  a_closed_empty: assert property (@(posedge clk) disable iff (rst)
    !cluster_open |-> (cluster_count == '0) && (cluster_sum == '0))
    else $error("closed cluster holds data");

  // Loading the final result of a set clears the set state.
  a_set_cleared: assert property (@(posedge clk) disable iff (rst)
    (out_load && final_phase) |=> !cluster_open && !overflow_seen)
    else $error("set state not cleared at end of set");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gap cluster mean filter testbench
// Sends coordinate sets to the block and checks every result beat against a
// cycle-free prediction of the clustering, the means and the overflow flag.
// ----------------------------------------------------------------------------
module testbench;
  import gcm_pkg::*;

  localparam int CoordBits     = CoordBitsDefault;
  localparam int MaxMembers    = MaxSetItemsDefault;
  localparam int SumBits       = CoordBits + $clog2(MaxMembers);
  localparam int CountBits     = $clog2(MaxMembers) + 1;
  localparam int CoordMax      = (1 << CoordBits) - 1;
  // Settling time for two divisions plus control, with some margin.
  localparam int SettleCycles  = 64;
  // Length of the deliberate output stall.
  localparam int HoldCycles    = 400;
  // Cycles without any accepted beat before the run is declared hung.
  localparam int WatchdogLimit = 3000;

  // One result beat as the block presents it.
  typedef struct packed {
    logic [CoordBits-1:0] line_position;
    logic                 has_line;
    logic                 end_of_set;
    logic                 count_overflow;
  } line_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CfgIndexBits-1:0] cfg_index = REG_IMAGE_SIZE;
  logic [CfgDataBits-1:0]  cfg_data  = '0;

  logic                 in_valid    = 1'b0;
  logic                 in_ready;
  logic [CoordBits-1:0] coordinate  = '0;
  logic                 last_of_set = 1'b0;

  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [CoordBits-1:0] line_position;
  logic                 has_line;
  logic                 end_of_set;
  logic                 count_overflow;

  gap_cluster_mean_filter #(
    .MAX_SET_ITEMS(MaxMembers),
    .COORD_BITS   (CoordBits)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .coordinate    (coordinate),
    .last_of_set   (last_of_set),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .line_position (line_position),
    .has_line      (has_line),
    .end_of_set    (end_of_set),
    .count_overflow(count_overflow)
  );

  // 4 ns clock period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction state. This mirrors what the block should hold: the register
  // values it was given and the cluster that is currently open.
  // --------------------------------------------------------------------------
  logic [ImageSizeBits-1:0]  image_size_cfg  = ImageSizeReset;
  logic [MinMembersBits-1:0] min_members_cfg = MinMembersReset;
  logic [CoordBits-1:0]      prev_coord      = '0;
  logic [SumBits-1:0]        cluster_sum     = '0;
  logic [CountBits-1:0]      cluster_count   = '0;
  logic                      cluster_open    = 1'b0;
  logic                      saturated       = 1'b0;

  // Result beats predicted but not yet seen at the output.
  line_result_t expected_lines[$];

  int errors          = 0;
  int beats_sent      = 0;
  int sets_sent       = 0;
  int results_checked = 0;
  int lines_seen      = 0;
  int overflow_seen   = 0;

  // Idle percentages of the two sides, changed per phase.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // A toggle of hold_request starts one long output stall.
  logic hold_request = 1'b0;
  logic hold_seen    = 1'b0;
  int   hold_left    = 0;
  int   quiet_cycles = 0;

  // Queues one result beat for the cluster that is open right now. The mean is
  // the truncated quotient of the member sum by the member count.
  task automatic queue_line(input logic line, input logic last);
    line_result_t r;
    logic [SumBits-1:0] quotient;
    quotient = (line && cluster_count != 0) ? cluster_sum / cluster_count : '0;
    r.line_position  = quotient[CoordBits-1:0];
    r.has_line       = line;
    r.end_of_set     = last;
    r.count_overflow = saturated;
    expected_lines.insert(expected_lines.size(), r);
  endtask

  // Advances the cluster state by one accepted coordinate and queues the
  // result beats that coordinate causes.
  task automatic cluster_update(input logic [CoordBits-1:0] c, input logic last);
    logic [CoordBits-1:0] gap;
    if (cluster_open) begin
      gap = (c >= prev_coord) ? c - prev_coord : prev_coord - c;
      if (GapFactor * int'(gap) < int'(image_size_cfg)) begin
        // Close enough to stay in the cluster, unless it is already full.
        if (cluster_count < MaxMembers) begin
          cluster_count = cluster_count + CountBits'(1);
          cluster_sum   = cluster_sum + SumBits'(c);
        end else begin
          saturated = 1'b1;
        end
      end else begin
        if (cluster_count > min_members_cfg) queue_line(1'b1, 1'b0);
        cluster_count = CountBits'(1);
        cluster_sum   = SumBits'(c);
      end
    end else begin
      cluster_open  = 1'b1;
      cluster_count = CountBits'(1);
      cluster_sum   = SumBits'(c);
    end
    prev_coord = c;
    if (last) begin
      queue_line(cluster_open && cluster_count > min_members_cfg, 1'b1);
      prev_coord    = '0;
      cluster_sum   = '0;
      cluster_count = '0;
      cluster_open  = 1'b0;
      saturated     = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Channel drivers.
  // --------------------------------------------------------------------------

  // Offers one coordinate beat, possibly after a short idle gap, and returns
  // at the edge where it is accepted. Valid stays high on return so that a
  // following beat can go out back to back.
  task automatic send_beat(input int c, input logic last);
    int gap_cycles;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      gap_cycles = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap_cycles) @(posedge clk);
    end
    in_valid    <= 1'b1;
    coordinate  <= c[CoordBits-1:0];
    last_of_set <= last;
    do @(posedge clk); while (!in_ready);
    cluster_update(c[CoordBits-1:0], last);
    beats_sent++;
    if (last) sets_sent++;
  endtask

  // Stops offering beats and waits until every predicted beat has come out,
  // then lets the block finish any work that produces no result.
  task automatic drain_block();
    in_valid <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Writes one register; only called while the block is idle.
  task automatic write_reg(input logic [CfgIndexBits-1:0] idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CfgDataBits-1:0];
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_IMAGE_SIZE) image_size_cfg = value[ImageSizeBits-1:0];
    else min_members_cfg = value[MinMembersBits-1:0];
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input int image_size_value, input int min_members_value);
    drain_block();
    write_reg(REG_IMAGE_SIZE, image_size_value);
    write_reg(REG_MIN_MEMBERS, min_members_value);
  endtask

  // Sends one set built from a few clusters: members of a cluster sit within
  // the joining distance of each other, clusters are separated by more than
  // it. About one set in ten is random, unsorted noise instead.
  task automatic send_cluster_set();
    int clusters;
    int members;
    int pos;
    int join_max;
    int c;
    logic noisy;
    join_max = (image_size_cfg == 0) ? -1 : (int'(image_size_cfg) - 1) / GapFactor;
    noisy    = ($urandom_range(99) < 10);
    clusters = $urandom_range(1, 4);
    pos      = $urandom_range(0, 600);
    for (int k = 0; k < clusters; k++) begin
      members = ($urandom_range(99) < 85) ? $urandom_range(1, 10) : $urandom_range(11, 40);
      for (int m = 0; m < members; m++) begin
        c = noisy ? $urandom_range(0, CoordMax) : ((pos > CoordMax) ? CoordMax : pos);
        send_beat(c, k == clusters - 1 && m == members - 1);
        pos += (join_max < 0) ? $urandom_range(0, 5) : $urandom_range(0, join_max);
      end
      pos += ((join_max < 0) ? 0 : join_max) + 1 + $urandom_range(0, 150);
    end
  endtask

  // Receiver: random stalls, plus one long stall each time it is requested.
  always @(posedge clk) begin
    if (hold_request != hold_seen) begin
      hold_seen <= hold_request;
      hold_left <= HoldCycles;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compares every accepted result beat with the oldest prediction.
  always @(posedge clk) begin : check_lines
    line_result_t got;
    line_result_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{line_position, has_line, end_of_set, count_overflow};
      results_checked++;
      if (got.has_line) lines_seen++;
      if (got.count_overflow) overflow_seen++;
      if (expected_lines.size() == 0) begin
        errors++;
        $display("%0t ERROR: unexpected result beat pos=%0d line=%0b end=%0b ovf=%0b",
                 $time, got.line_position, got.has_line, got.end_of_set,
                 got.count_overflow);
      end else begin
        want = expected_lines.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t ERROR: expected pos=%0d line=%0b end=%0b ovf=%0b, got pos=%0d line=%0b end=%0b ovf=%0b",
                   $time, want.line_position, want.has_line, want.end_of_set,
                   want.count_overflow, got.line_position, got.has_line,
                   got.end_of_set, got.count_overflow);
        end
      end
    end
  end

  // Ends a hung run: the count restarts on any accepted beat on any channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t ERROR: no beat accepted for %0d cycles, %0d results outstanding",
               $time, WatchdogLimit, expected_lines.size());
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Runs on the reset register values: eight points spaced 5 apart form one
  // cluster (5 * 54 < 512), which is reported because 8 > 6. The far point at
  // the top of the range ends the set as a lone, unreported cluster.
  task automatic test_reset_defaults();
    for (int i = 0; i < 8; i++) send_beat(i * 5, 1'b0);
    send_beat(CoordMax, 1'b1);
  endtask

  // With a zero image size not even equal neighbors join, so each point is a
  // cluster of its own and every one is reported when the minimum is zero.
  task automatic test_zero_image_size();
    configure(0, 0);
    send_beat(10, 1'b0);
    send_beat(10, 1'b0);
    send_beat(20, 1'b1);
  endtask

  // A step downward is measured by its size, so 95 after 100 still joins.
  // The first point of a set never joins the previous set's last cluster,
  // even when it lies right next to it.
  task automatic test_unsorted_and_set_start();
    configure(512, 1);
    send_beat(100, 1'b0);
    send_beat(95, 1'b0);
    send_beat(3000, 1'b0);
    send_beat(2995, 1'b1);
    send_beat(2996, 1'b1);
    send_beat(50, 1'b0);
    send_beat(52, 1'b1);
  endtask

  // Largest minimum: no cluster can be reported, not even a full one. Zero
  // minimum: a single-point set gives its own coordinate as the line.
  task automatic test_min_members_extremes();
    configure(512, 1024);
    send_beat(7, 1'b0);
    send_beat(7, 1'b1);
    configure(4095, 0);
    send_beat(4095, 1'b1);
  endtask

  // Fills one cluster one point past its capacity. The flag must ride on the
  // line that the break produces and on the end beat of the same set, then
  // clear for the next set.
  task automatic test_count_saturation();
    configure(512, 1023);
    for (int i = 0; i < MaxMembers + 1; i++) send_beat(4000 + (i % 2), 1'b0);
    send_beat(100, 1'b1);
    send_beat(5, 1'b1);
  endtask

  // Stalls the output for a long stretch while a set in which every point
  // closes a cluster keeps arriving, so the block backs up into its input.
  task automatic test_output_holdoff();
    configure(1, 0);
    hold_request <= ~hold_request;
    for (int i = 0; i < 30; i++) send_beat(200 + 2 * i + $urandom_range(0, 1), i == 29);
  endtask

  // The sender stops in the middle of a set until all output has drained;
  // the open cluster must survive the pause.
  task automatic test_sender_pause();
    configure(512, 2);
    send_beat(0, 1'b0);
    send_beat(3, 1'b0);
    send_beat(6, 1'b0);
    drain_block();
    send_beat(7, 1'b0);
    send_beat(200, 1'b0);
    send_beat(201, 1'b1);
  endtask

  task automatic run_random_phase(input int image_size_value, input int min_members_value,
                                  input int sender_idle, input int receiver_idle,
                                  input int beats);
    int stop_at;
    configure(image_size_value, min_members_value);
    send_idle_pct = sender_idle;
    recv_idle_pct = receiver_idle;
    stop_at = beats_sent + beats;
    while (beats_sent < stop_at) send_cluster_set();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 13;
    recv_idle_pct = 67;
    test_reset_defaults();
    test_zero_image_size();
    test_unsorted_and_set_start();
    test_min_members_extremes();
    test_count_saturation();
    test_output_holdoff();
    test_sender_pause();

    // Widest threshold, every cluster reported; then the narrowest threshold
    // with the idle pattern swapped; then a middle setting at full rate.
    run_random_phase(4095, 0, 13, 67, 30);
    run_random_phase(1, 2, 67, 13, 30);
    run_random_phase(700, 5, 0, 0, 30);

    drain_block();
    $display("Covered %0d coordinate beats in %0d sets, including a saturated cluster.",
             beats_sent, sets_sent);
    $display("Checked %0d result beats: %0d cluster means, %0d with the overflow flag.",
             results_checked, lines_seen, overflow_seen);
    if (errors == 0 && expected_lines.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
